// ===== src/bsvm_pkg.sv =====
package bsvm_pkg;

    localparam int NUM_BANKS_DEF  = 16;
    localparam int BANK_WORDS_DEF = 2048;
    localparam int BANK_SEL_W     = 4;
    localparam int MAX_BANKS      = 1 << BANK_SEL_W;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FILL  = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_BANK    = 3'd1;
    localparam logic [2:0] ST_BAD_WIDTH   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW    = 3'd3;
    localparam logic [2:0] ST_INDEX       = 3'd4;
    localparam logic [2:0] ST_REVERSED    = 3'd5;
    localparam logic [2:0] ST_FILL_BOUNDS = 3'd6;

    localparam logic [2:0] LG_WORD = 3'd5;

    typedef struct packed {
        logic       ok;
        logic [2:0] lg;
    } t_width;

    function automatic t_width f_width(input logic [5:0] bits);
        t_width w;
        w.ok = 1'b1;
        w.lg = 3'd0;
        case (bits)
            6'd1:    w.lg = 3'd0;
            6'd2:    w.lg = 3'd1;
            6'd4:    w.lg = 3'd2;
            6'd8:    w.lg = 3'd3;
            6'd16:   w.lg = 3'd4;
            6'd32:   w.lg = LG_WORD;
            default: w.ok = 1'b0;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] f_mask(input logic [2:0] lg);
        logic [31:0] m;
        case (lg)
            3'd0:    m = 32'h0000_0001;
            3'd1:    m = 32'h0000_0003;
            3'd2:    m = 32'h0000_000F;
            3'd3:    m = 32'h0000_00FF;
            3'd4:    m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ===== src/bsvm_ram.sv =====
module bsvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/banked_subword_variable_memory.sv =====
// channel | direction | handshake                 | payload
// in      | input     | i_in_valid / o_in_stall   | cmd, bank_select, access_bits, item_index,
//         |           |                           | write_data, fill_end
// out     | output    | o_out_valid / i_out_stall | read_data, status
//
// One item at a time through the single RAM port: a read or sub-word write passes decode, RAM
// read, extract or merge-write and result; a full-word write or a failed command passes decode,
// execute and result; a fill passes decode, execute, one RAM write per word and result.
// After reset a clearing pass zeroes all USED_BANKS*BANK_WORDS words (USED_BANKS is NUM_BANKS
// capped at 16; at most 16 banks are addressable) with o_in_stall high.
// A result waits in the output register under i_out_stall while the next beat is accepted.
module banked_subword_variable_memory #(
    parameter int NUM_BANKS  = bsvm_pkg::NUM_BANKS_DEF,
    parameter int BANK_WORDS = bsvm_pkg::BANK_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_bank_select,
    input  logic [5:0]  i_access_bits,
    input  logic [15:0] i_item_index,
    input  logic [31:0] i_write_data,
    input  logic [11:0] i_fill_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic [2:0]  o_status
);

    import bsvm_pkg::*;

    localparam int USED_BANKS = (NUM_BANKS < MAX_BANKS) ? NUM_BANKS : MAX_BANKS;
    localparam int DEPTH      = USED_BANKS * BANK_WORDS;
    localparam int AW         = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_FILL,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_READ,
        OP_WRITE,
        OP_RMW,
        OP_FILL
    } t_op;

    t_state      r_state;
    t_op         r_op;
    logic [AW-1:0] r_addr;
    logic [11:0] r_count;
    logic [2:0]  r_lg;
    logic [4:0]  r_shift;
    logic [31:0] r_data;
    logic [2:0]  r_status;
    logic [31:0] r_rdata;
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic [2:0]  r_out_status;

    t_width      n_width;
    t_op         n_op;
    logic [2:0]  n_status;
    logic [15:0] n_word;
    logic [15:0] n_bitpos;
    logic [AW-1:0] n_addr;
    logic [AW-1:0] n_bank_base;
    logic [11:0] n_count;
    logic        n_bank_bad;
    logic        n_range_bad;
    logic        n_overflow;

    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;
    logic [31:0]   mask;
    logic [31:0]   merged;
    logic [31:0]   extracted;
    logic          accept;
    logic          out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_width     = f_width(i_access_bits);
        n_word      = i_item_index >> (LG_WORD - n_width.lg);
        n_bitpos    = i_item_index << n_width.lg;
        n_bank_bad  = 7'(i_bank_select) >= 7'(NUM_BANKS);
        n_range_bad = {1'b0, n_word} >= 17'(BANK_WORDS);
        n_overflow  = (n_width.lg != LG_WORD) && (i_write_data > f_mask(n_width.lg));
        n_bank_base = AW'(i_bank_select) * AW'(BANK_WORDS);
        n_addr      = n_bank_base + AW'(n_word);
        n_count     = i_fill_end - i_item_index[11:0];
        n_status    = ST_OK;
        n_op        = OP_NONE;
        case (i_cmd)
            CMD_READ: begin
                if (!n_width.ok) begin
                    n_status = ST_BAD_WIDTH;
                end else if (n_bank_bad) begin
                    n_status = ST_BAD_BANK;
                end else if (n_range_bad) begin
                    n_status = ST_INDEX;
                end else begin
                    n_op = OP_READ;
                end
            end
            CMD_WRITE: begin
                if (n_bank_bad) begin
                    n_status = ST_BAD_BANK;
                end else if (!n_width.ok) begin
                    n_status = ST_BAD_WIDTH;
                end else if (n_range_bad) begin
                    n_status = ST_INDEX;
                end else if (n_overflow) begin
                    n_status = ST_OVERFLOW;
                end else if (n_width.lg == LG_WORD) begin
                    n_op = OP_WRITE;
                end else begin
                    n_op = OP_RMW;
                end
            end
            CMD_FILL: begin
                n_addr = n_bank_base + AW'(i_item_index);
                if (n_bank_bad) begin
                    n_status = ST_BAD_BANK;
                end else if (i_item_index > {4'b0, i_fill_end}) begin
                    n_status = ST_REVERSED;
                end else if (17'(i_fill_end) > 17'(BANK_WORDS)) begin
                    n_status = ST_FILL_BOUNDS;
                end else if (n_count != 12'd0) begin
                    n_op = OP_FILL;
                end
            end
            default: begin
                n_op = OP_NONE;
            end
        endcase
    end

    always_comb begin
        mask      = f_mask(r_lg);
        merged    = (ram_rdata & ~(mask << r_shift)) | (r_data << r_shift);
        extracted = (ram_rdata >> r_shift) & mask;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = r_addr;
        ram_wdata = r_data;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            S_EXEC: begin
                ram_we = (r_op == OP_WRITE);
                ram_re = (r_op == OP_READ) || (r_op == OP_RMW);
            end
            S_WAIT: begin
                ram_we    = (r_op == OP_RMW);
                ram_wdata = merged;
            end
            S_FILL: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    bsvm_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (ram_re),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op     <= n_op;
                        r_status <= n_status;
                        r_addr   <= n_addr;
                        r_count  <= n_count;
                        r_lg     <= n_width.lg;
                        r_shift  <= n_bitpos[4:0];
                        r_data   <= i_write_data;
                        r_rdata  <= '0;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_op)
                        OP_READ, OP_RMW: r_state <= S_WAIT;
                        OP_FILL:         r_state <= S_FILL;
                        default:         r_state <= S_DONE;
                    endcase
                end
                S_WAIT: begin
                    if (r_op == OP_READ) begin
                        r_rdata <= extracted;
                    end
                    r_state <= S_DONE;
                end
                S_FILL: begin
                    r_addr  <= r_addr + 1'b1;
                    r_count <= r_count - 1'b1;
                    if (r_count == 12'd1) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_data   <= r_rdata;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_status    = r_out_status;

endmodule

// ===== src/bsvm_chk.sv =====
module bsvm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_read_data,
    input logic [2:0]  o_status
);

    import bsvm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_read_data) && $stable(o_status))
        else $error("stalled result beat changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_read_data == 32'd0))
        else $error("failed command returned nonzero data");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not held off while a beat is in flight");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("store accepts or answers before the clearing pass");

endmodule

bind banked_subword_variable_memory bsvm_chk u_bsvm_chk (.*);
